// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the line wrapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/glw_pkg.sv =====
// Shared types and constants of the greedy text line wrapper.
package glw_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int CFG_W           = 7;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT,
    ST_DROP,
    ST_PASS
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [7:0] line_char;
    logic       has_char;
    logic       end_of_line;
    logic       end_of_text;
  } out_item_t;

endpackage

// ===== rtl/glw_if.sv =====
// Handshake channel interfaces of the line wrapper: text input, line output, config.
interface glw_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface glw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_char;
  logic       has_char;
  logic       end_of_line;
  logic       end_of_text;

  modport source (output valid, output line_char, output has_char, output end_of_line,
                  output end_of_text, input ready);
  modport sink   (input valid, input line_char, input has_char, input end_of_line,
                  input end_of_text, output ready);
endinterface

interface glw_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] line_columns;

  modport source (output valid, output line_columns, input ready);
  modport sink   (input valid, input line_columns, output ready);
endinterface

// ===== rtl/glw_cell.sv =====
// One pending-byte cell: loads a new byte or takes its right neighbor's byte.
module glw_cell
  import glw_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] right_byte,
  input  logic [7:0] wr_byte,
  output logic [7:0] byte_q,
  output logic       is_space
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= right_byte;
    end else if (ctrl.load) begin
      byte_r <= wr_byte;
    end
  end

  assign byte_q   = byte_r;
  assign is_space = (byte_r == CH_SPACE);

endmodule

// ===== rtl/glw_chain.sv =====
// Row of pending-byte cells; shifting moves every byte one cell toward the front.
module glw_chain
  import glw_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_COLUMNS + 1,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             shift,
  input  logic             load_en,
  input  logic [IDX_W-1:0] load_idx,
  input  logic [7:0]       wr_byte,
  output logic [7:0]       front_byte,
  output logic [DEPTH-1:0] space_vec
);

  logic [7:0] bytes [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] right;

    assign ctrl.shift = shift;
    assign ctrl.load  = load_en && (load_idx == IDX_W'(i));

    if (i == DEPTH - 1) begin : g_last
      assign right = 8'h00;
    end else begin : g_mid
      assign right = bytes[i+1];
    end

    glw_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .right_byte (right),
      .wr_byte    (wr_byte),
      .byte_q     (bytes[i]),
      .is_space   (space_vec[i])
    );
  end

  assign front_byte = bytes[0];

endmodule

// ===== rtl/greedy_text_line_wrapper.sv =====
// Greedy text line wrapper top level: control sequencer over a row of byte cells.
// A plain byte is accepted, then the pending length is checked. A line break scans C+1
// entries (C = columns), emits its items, drops the next line's leading spaces and
// rechecks; a flush scans each pending byte, then emits its items. Output stalls hold
// the emit step; the scan takes one entry per cycle. No byte is accepted outside idle.
// Reset (rst_n low at a clock edge) empties the pending row at once; no clearing pass.
module greedy_text_line_wrapper
  import glw_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic      clk,
  input  logic      rst_n,
  glw_in_if.sink    in_ch,
  glw_out_if.source out_ch,
  glw_cfg_if.sink   cfg_ch
);

`include "assert_macros.svh"

  // The row holds one byte more than a full line, so a break point can sit just past it.
  localparam int DEPTH = MAX_COLUMNS + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             skip_r, skip_nxt;
  logic [CFG_W-1:0] cfg_r, cfg_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  out_item_t        hold_r, hold_nxt;

  // Scan state: position, last limit, and what the scan has found so far.
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] ns_len_r, ns_len_nxt;
  logic [CNT_W-1:0] trim_sp_r, trim_sp_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic             brk_r, brk_nxt;
  logic             eot_r, eot_nxt;

  logic             shift;
  logic             load_en;
  logic [7:0]       front_byte;
  logic [DEPTH-1:0] space_vec;

  logic [8:0]       cfg_ext;
  logic [CNT_W-1:0] cols;
  logic             in_fire;
  logic             out_free;
  logic             is_pass;
  logic             is_flush;
  logic             is_dropped;
  logic             cur_sp;
  logic             scan_last;
  logic             step_found;
  logic [CNT_W-1:0] step_trim;
  logic [CNT_W-1:0] step_ns;
  logic             drop_more;
  logic             emit_pop;
  logic             eot_out;

  // Saturate the column count at the row capacity.
  assign cfg_ext = {2'b00, cfg_r};
  assign cols    = (cfg_ext > 9'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : CNT_W'(cfg_ext);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Classify the incoming item.
  assign is_pass    = (cols == '0);
  assign is_flush   = (in_ch.opcode == OP_EOT) || (in_ch.char_code == CH_NEWLINE);
  assign is_dropped = skip_r && (in_ch.char_code == CH_SPACE);

  // One scan step: remember the last space and the trimmed length in front of it.
  assign cur_sp     = space_vec[k_r[IDX_W-1:0]];
  assign scan_last  = (k_r == lim_r);
  assign step_found = found_r || cur_sp;
  assign step_trim  = cur_sp ? ns_len_r : trim_sp_r;
  assign step_ns    = cur_sp ? ns_len_r : CNT_W'(k_r + 1'b1);

  // Leading spaces of the next line are dropped from the front.
  assign drop_more = (count_r != '0) && space_vec[0];

  glw_chain #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk        (clk),
    .shift      (shift),
    .load_en    (load_en),
    .load_idx   (count_r[IDX_W-1:0]),
    .wr_byte    (in_ch.char_code),
    .front_byte (front_byte),
    .space_vec  (space_vec)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_pass) begin
            state_nxt = ST_PASS;
          end else if (is_flush) begin
            state_nxt = (count_r == '0) ? ST_EMIT : ST_SCAN;
          end else if (!is_dropped) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        state_nxt = (count_r > cols) ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (len_r <= CNT_W'(1))) begin
          state_nxt = brk_r ? ST_DROP : ST_IDLE;
        end
      end
      ST_DROP: begin
        if (!drop_more) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_PASS: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_nxt     = count_r;
    skip_nxt      = skip_r;
    cfg_nxt       = cfg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    hold_nxt      = hold_r;
    k_nxt         = k_r;
    lim_nxt       = lim_r;
    found_nxt     = found_r;
    ns_len_nxt    = ns_len_r;
    trim_sp_nxt   = trim_sp_r;
    len_nxt       = len_r;
    brk_nxt       = brk_r;
    eot_nxt       = eot_r;
    shift         = 1'b0;
    load_en       = 1'b0;

    if (cfg_ch.valid && cfg_ch.ready) begin
      cfg_nxt = cfg_ch.line_columns;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_pass) begin
            // Echo the byte unwrapped; end of text closes the one line empty.
            if (in_ch.opcode == OP_EOT) begin
              hold_nxt = '{line_char: 8'h00, has_char: 1'b0, end_of_line: 1'b1,
                           end_of_text: 1'b1};
            end else begin
              hold_nxt = '{line_char: in_ch.char_code, has_char: 1'b1, end_of_line: 1'b0,
                           end_of_text: 1'b0};
            end
            count_nxt = '0;
            skip_nxt  = 1'b1;
          end else if (is_flush) begin
            // Flush the pending line, trimmed of trailing spaces.
            brk_nxt     = 1'b0;
            eot_nxt     = in_ch.opcode;
            len_nxt     = '0;
            lim_nxt     = CNT_W'(count_r - 1'b1);
            k_nxt       = '0;
            found_nxt   = 1'b0;
            ns_len_nxt  = '0;
            trim_sp_nxt = '0;
          end else if (!is_dropped) begin
            skip_nxt = 1'b0;
            if (count_r < CNT_W'(DEPTH)) begin
              load_en   = 1'b1;
              count_nxt = CNT_W'(count_r + 1'b1);
            end
          end
        end
      end
      ST_CHECK: begin
        if (count_r > cols) begin
          // Start a break: search the first C+1 bytes for the last space.
          brk_nxt     = 1'b1;
          eot_nxt     = 1'b0;
          lim_nxt     = cols;
          k_nxt       = '0;
          found_nxt   = 1'b0;
          ns_len_nxt  = '0;
          trim_sp_nxt = '0;
        end
      end
      ST_SCAN: begin
        k_nxt       = CNT_W'(k_r + 1'b1);
        found_nxt   = step_found;
        ns_len_nxt  = step_ns;
        trim_sp_nxt = step_trim;
        if (scan_last) begin
          if (brk_r) begin
            len_nxt = step_found ? step_trim : cols;
          end else begin
            len_nxt = step_ns;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (len_r == '0) begin
            out_nxt = '{line_char: 8'h00, has_char: 1'b0, end_of_line: 1'b1,
                        end_of_text: eot_r};
          end else begin
            out_nxt = '{line_char: front_byte, has_char: 1'b1,
                        end_of_line: (len_r == CNT_W'(1)),
                        end_of_text: (len_r == CNT_W'(1)) && eot_r};
            shift     = 1'b1;
            count_nxt = CNT_W'(count_r - 1'b1);
            len_nxt   = CNT_W'(len_r - 1'b1);
          end
          // A flush leaves the row empty; trimmed spaces are discarded with it.
          if (!brk_r && (len_r <= CNT_W'(1))) begin
            count_nxt = '0;
            skip_nxt  = 1'b1;
          end
        end
      end
      ST_DROP: begin
        if (drop_more) begin
          shift     = 1'b1;
          count_nxt = CNT_W'(count_r - 1'b1);
        end else begin
          skip_nxt = (count_r == '0);
        end
      end
      ST_PASS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = hold_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      skip_r      <= 1'b1;
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      skip_r      <= skip_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    hold_r    <= hold_nxt;
    k_r       <= k_nxt;
    lim_r     <= lim_nxt;
    found_r   <= found_nxt;
    ns_len_r  <= ns_len_nxt;
    trim_sp_r <= trim_sp_nxt;
    len_r     <= len_nxt;
    brk_r     <= brk_nxt;
    eot_r     <= eot_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.line_char   = out_r.line_char;
  assign out_ch.has_char    = out_r.has_char;
  assign out_ch.end_of_line = out_r.end_of_line;
  assign out_ch.end_of_text = out_r.end_of_text;

  assign emit_pop = (state_r == ST_EMIT) && out_free && (len_r > CNT_W'(1));
  assign eot_out  = out_valid_r && out_r.end_of_text;

  `ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(DEPTH), "pending count beyond row depth")
  `ASSERT_ALWAYS(a_skip_empty, !skip_r || (count_r == '0), "skip flag with bytes pending")
  `ASSERT_NEXT(a_emit_pop, emit_pop, count_r == CNT_W'($past(count_r) - 1'b1), "missed pop")
  `ASSERT_ALWAYS(a_eot_eol, !eot_out || out_r.end_of_line, "end of text without end of line")

endmodule
